### sv/gfmv_pkg.sv
// ----------------------------------------------------------------------------
// GF(251) matrix-vector MAC package
// Shared types, codes and widths of the column-major multiply-accumulate block.
// ----------------------------------------------------------------------------
package gfmv_pkg;

    localparam int OPCODE_W    = 2;
    localparam int BYTE_W      = 8;
    localparam int ROW_COUNT_W = 11;
    localparam int ROW_IDX_W   = 10;
    localparam int GF_PRIME    = 251;

    // Width of the unreduced sum of one 8x8 product and one stored residue.
    localparam int FOLD_W      = 17;
    // Number of fold cells needed to bring a FOLD_W value below 256.
    localparam int NUM_FOLDS   = 3;

    typedef enum logic [OPCODE_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_MAC   = 2'd1,
        OP_DRAIN = 2'd2,
        OP_RSVD  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_FOLD
    } state_t;

    typedef struct packed {
        logic              valid;
        logic [FOLD_W-1:0] data;
    } fold_t;

endpackage

### sv/gfmv_if.sv
// ----------------------------------------------------------------------------
// GF(251) matrix-vector MAC channels
// Valid/ready interfaces for the command, result and configuration words.
// ----------------------------------------------------------------------------
interface gfmv_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [gfmv_pkg::OPCODE_W-1:0]       opcode;
    logic [gfmv_pkg::BYTE_W-1:0]         entry;
    logic [gfmv_pkg::BYTE_W-1:0]         coef;

    modport source (output valid, output opcode, output entry, output coef, input ready);
    modport sink   (input valid, input opcode, input entry, input coef, output ready);
endinterface

interface gfmv_res_if;
    logic                                valid;
    logic                                ready;
    logic [gfmv_pkg::BYTE_W-1:0]         row_value;
    logic [gfmv_pkg::ROW_IDX_W-1:0]      row_index;
    logic                                last_row;

    modport source (output valid, output row_value, output row_index, output last_row,
                    input ready);
    modport sink   (input valid, input row_value, input row_index, input last_row,
                    output ready);
endinterface

interface gfmv_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [gfmv_pkg::ROW_COUNT_W-1:0]    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### sv/gfmv_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module gfmv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/gfmv_fold_cell.sv
// ----------------------------------------------------------------------------
// GF(251) fold cell
// One registered folding step: since 256 = 5 mod 251, hi*256 + lo becomes
// hi*5 + lo, which keeps the residue and shrinks the value.
// ----------------------------------------------------------------------------
module gfmv_fold_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  gfmv_pkg::fold_t din,
    output gfmv_pkg::fold_t dout
);
    import gfmv_pkg::*;

    logic              valid_reg;
    logic [FOLD_W-1:0] data_reg;
    logic [FOLD_W-1:0] data_next;
    logic [FOLD_W-1:0] hi_ext;

    assign hi_ext    = FOLD_W'(din.data[FOLD_W-1:BYTE_W]);
    assign data_next = (hi_ext << 2) + hi_ext + FOLD_W'(din.data[BYTE_W-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= din.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign dout.valid = valid_reg;
    assign dout.data  = data_reg;

endmodule

### sv/gf251_matvec_col_major_mac.sv
// ----------------------------------------------------------------------------
// GF(251) column-major matrix-vector multiply-accumulate
// Keeps one residue per row and walks the rows with a wrapping pointer.
//
//   Channel  Dir  Word
//   cmd      in   opcode, entry, coef
//   res      out  row_value, row_index, last_row (one word per drain)
//   cfg      in   row_count, always ready
//
// Load and multiply-accumulate each pass through the RAM read, the sum register,
// three fold cells and the write back, one command in flight at a time.
// A drain passes the RAM read, then the result register; opcode 3 changes nothing.
// A drain holds in the fetch state while the result register is still full.
// Reset clears the pointer and sets row_count to 1024; accumulators are not
// cleared and must be loaded before they are read.
// ----------------------------------------------------------------------------
module gf251_matvec_col_major_mac #(
    parameter int MAX_ROWS = 1024
) (
    input  logic       clk,
    input  logic       rst_n,
    gfmv_cfg_if.sink   cfg,
    gfmv_cmd_if.sink   cmd,
    gfmv_res_if.source res
);
    import gfmv_pkg::*;

    localparam int PTR_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CNT_W = $clog2(MAX_ROWS + 1);
    localparam int CMP_W = (CNT_W > ROW_COUNT_W) ? CNT_W : ROW_COUNT_W;

    state_t                 state_reg, state_next;
    logic [ROW_COUNT_W-1:0] row_count_reg;
    logic [PTR_W-1:0]       ptr_reg, ptr_next;
    logic [PTR_W-1:0]       idx_reg;
    logic                   wraps_reg;
    opcode_t                op_reg;
    logic [BYTE_W-1:0]      entry_reg;
    logic [BYTE_W-1:0]      coef_reg;

    logic                   out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]      row_value_reg;
    logic [PTR_W-1:0]       row_index_reg;
    logic                   last_row_reg;

    fold_t                  x_reg;
    fold_t                  x_next;
    fold_t                  chain [NUM_FOLDS+1];

    opcode_t                op_in;
    logic                   accept;
    logic                   busy_op;
    logic                   load_out;
    logic                   out_free;
    logic [CMP_W-1:0]       count_ext;
    logic [CMP_W-1:0]       max_rows_c;
    logic [CMP_W-1:0]       rows_eff;
    logic [CMP_W-1:0]       ptr_inc;
    logic                   wraps;

    logic [BYTE_W-1:0]      acc_rdata;
    logic                   ram_we;
    logic [BYTE_W-1:0]      ram_wdata;
    logic [BYTE_W-1:0]      fold_low;
    logic [2*BYTE_W-1:0]    product;

    // Configuration.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= ROW_COUNT_W'(1024);
        end
        else if (cfg.valid && cfg.ready)
        begin
            row_count_reg <= cfg.data;
        end
    end

    // Row pointer and its wrap.
    assign count_ext  = CMP_W'(row_count_reg);
    assign max_rows_c = CMP_W'(MAX_ROWS);
    assign ptr_inc    = CMP_W'(ptr_reg) + CMP_W'(1);

    always_comb
    begin
        priority if (count_ext == '0)
        begin
            rows_eff = CMP_W'(1);
        end
        else if (count_ext > max_rows_c)
        begin
            rows_eff = max_rows_c;
        end
        else
        begin
            rows_eff = count_ext;
        end
    end

    assign wraps    = (ptr_inc >= rows_eff);
    assign ptr_next = wraps ? '0 : PTR_W'(ptr_inc);

    assign op_in      = opcode_t'(cmd.opcode);
    assign cmd.ready  = (state_reg == ST_IDLE);
    assign accept     = cmd.valid && cmd.ready;
    assign busy_op    = accept && (op_in != OP_RSVD);
    assign out_free   = !out_valid_reg || res.ready;

    // Product plus stored residue, or the raw load value.
    assign product = (2*BYTE_W)'(entry_reg) * (2*BYTE_W)'(coef_reg);

    // Sequencer.
    always_comb
    begin
        state_next   = state_reg;
        x_next.valid = 1'b0;
        x_next.data  = (op_reg == OP_MAC) ? FOLD_W'(product) + FOLD_W'(acc_rdata)
                                          : FOLD_W'(entry_reg);
        load_out     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (busy_op)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                if (op_reg == OP_DRAIN)
                begin
                    if (out_free)
                    begin
                        load_out   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    x_next.valid = 1'b1;
                    state_next   = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                if (chain[NUM_FOLDS].valid)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ptr_reg   <= '0;
            x_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            x_reg     <= x_next;
            if (busy_op)
            begin
                ptr_reg <= ptr_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_op)
        begin
            op_reg    <= op_in;
            entry_reg <= cmd.entry;
            coef_reg  <= cmd.coef;
            idx_reg   <= ptr_reg;
            wraps_reg <= wraps;
        end
    end

    // Chain of fold cells.
    assign chain[0] = x_reg;

    for (genvar k = 0; k < NUM_FOLDS; k++)
    begin : g_fold
        gfmv_fold_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .din   (chain[k]),
            .dout  (chain[k+1])
        );
    end

    assign fold_low  = chain[NUM_FOLDS].data[BYTE_W-1:0];
    assign ram_wdata = (fold_low >= BYTE_W'(GF_PRIME)) ? fold_low - BYTE_W'(GF_PRIME)
                                                       : fold_low;
    assign ram_we    = chain[NUM_FOLDS].valid;

    gfmv_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_ROWS)
    ) u_acc_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (ram_wdata),
        .re    (busy_op),
        .raddr (ptr_reg),
        .rdata (acc_rdata)
    );

    // Result register.
    always_comb
    begin
        priority if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            row_value_reg <= acc_rdata;
            row_index_reg <= idx_reg;
            last_row_reg  <= wraps_reg;
        end
    end

    assign res.valid     = out_valid_reg;
    assign res.row_value = row_value_reg;
    assign res.row_index = ROW_IDX_W'(row_index_reg);
    assign res.last_row  = last_row_reg;

    // The accumulator RAM is only written while a fold is in flight.
    a_write_in_fold: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_FOLD))
        else $error("accumulator written outside the fold state");

    // A sum launched from x_reg passes every fold cell and is then written.
    a_chain_latency: assert property (@(posedge clk) disable iff (!rst_n)
        x_reg.valid |-> ##NUM_FOLDS ram_we)
        else $error("fold chain lost a word");

    // Every written residue is fully reduced.
    a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (ram_wdata < BYTE_W'(GF_PRIME)))
        else $error("unreduced residue written");

    // The row pointer never leaves the accumulator range.
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(ptr_reg) < max_rows_c)
        else $error("row pointer out of range");

endmodule
